// ===== sv/ihgt_pkg.sv =====
// Shared types, constants and helpers for the IGMPv2 host group table.
// Used by ihgt_slot_table, ihgt_slot_unit and igmp_host_group_table.
package ihgt_pkg;

    localparam int GroupSlots = 8;
    localparam int SlotIdxW   = (GroupSlots > 1) ? $clog2(GroupSlots) : 1;

    localparam logic [2:0] OpJoin      = 3'd0;
    localparam logic [2:0] OpLeave     = 3'd1;
    localparam logic [2:0] OpQuery     = 3'd2;
    localparam logic [2:0] OpTick      = 3'd3;
    localparam logic [2:0] OpReportAll = 3'd4;
    localparam logic [2:0] OpLeaveAll  = 3'd5;

    localparam logic       KindReport = 1'b0;
    localparam logic       KindLeave  = 1'b1;

    localparam logic [31:0] AllSystemsGroup = 32'hE000_0001;
    localparam logic [7:0]  MulticastMask   = 8'hE0;
    localparam logic [7:0]  QueryVerIhl     = 8'h45;
    localparam logic [7:0]  QueryType       = 8'h11;
    localparam logic [7:0]  JoinDelayTicks  = 8'd2;
    localparam logic [7:0]  ReportAllMax    = 8'(500 / 100);
    localparam logic [15:0] LfsrTaps        = 16'hB400;

    localparam logic [15:0] SeedReset  = 16'd1;
    localparam logic        RegSeedIdx = 1'b0;

    typedef enum logic [1:0] {
        MODE_NON_MEMBER = 2'd0,
        MODE_DELAYING   = 2'd1,
        MODE_IDLE       = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] group_ip;
        logic [7:0]  version_and_header_length;
        logic [7:0]  message_type;
        logic [7:0]  max_response_time;
    } ihgt_req_t;

    typedef struct packed {
        logic        message_kind;
        logic [31:0] target_group;
        logic [15:0] packet_id;
        logic        last;
    } ihgt_rsp_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [7:0]  timer;
        mode_t       mode;
    } ihgt_slot_t;

    typedef struct packed {
        ihgt_slot_t  slot;
        logic        emit;
        logic        kind;
        logic [31:0] group;
        logic        stop;
        logic        lfsr_step;
    } ihgt_unit_res_t;

    // 16 = 1 mod 5, so nibble sums keep the residue
    function automatic logic [2:0] mod5(input logic [15:0] v);
        logic [5:0] s;
        logic [4:0] r;
        s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
        r = 5'(s[5:4]) + 5'(s[3:0]);
        if (r >= 5'd10)
        begin
            r = r - 5'd10;
        end
        if (r >= 5'd5)
        begin
            r = r - 5'd5;
        end
        return r[2:0];
    endfunction

endpackage

// ===== sv/igmp_host_group_table.sv =====
// Top level of the IGMPv2 host group table: sequencer, counters, LFSR, APB.
// Depends on ihgt_pkg, ihgt_slot_table and ihgt_slot_unit.
//
// Usage:
//   An operation beat is taken when start is high and busy is low. The
//   sequencer then walks the slots one per cycle through the shared slot
//   unit; join and leave finish early at the slot that acts. busy stays
//   high through the walk and drops in the cycle that shows the final message.
//   Each report or leave message is a beat on rsp, marked by rsp_valid for
//   exactly one cycle; rsp.last marks the final beat of an operation. One
//   message is held back a slot so that last is known when it goes out.
//   The receiver cannot stall: every beat must be taken when shown.
//   Reset clears the table, the packet id counter and loads seed 1 into
//   the LFSR. The APB register at address 0 holds random_seed; a write also
//   reloads the LFSR; the user must write only while busy is low, unenforced.
module igmp_host_group_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ihgt_pkg::ihgt_req_t req,
    output logic                rsp_valid,
    output ihgt_pkg::ihgt_rsp_t rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ihgt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    localparam logic [SlotIdxW-1:0] LastSlot = SlotIdxW'(GroupSlots - 1);

    state_t              state_reg;
    logic [SlotIdxW-1:0] idx_reg;
    ihgt_req_t           req_reg;
    logic [15:0]         counter_reg;
    logic [15:0]         lfsr_reg;
    logic [15:0]         seed_reg;
    logic                pend_valid_reg;
    ihgt_rsp_t           pend_reg;
    logic                rsp_valid_reg;
    ihgt_rsp_t           rsp_reg;

    ihgt_slot_t          cur_slot;
    ihgt_unit_res_t      ures;
    logic [15:0]         lfsr_adv;
    logic                cfg_wr;
    logic                scan_end;

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == RegSeedIdx) ? {16'd0, seed_reg} : 32'd0;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == RegSeedIdx);
    assign lfsr_adv  = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LfsrTaps : 16'd0);
    assign scan_end  = ures.stop || (idx_reg == LastSlot);

    ihgt_slot_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (idx_reg),
        .rd_slot (cur_slot),
        .wr_en   (state_reg == ST_SCAN),
        .wr_idx  (idx_reg),
        .wr_slot (ures.slot)
    );

    ihgt_slot_unit u_unit (
        .req      (req_reg),
        .slot     (cur_slot),
        .lfsr_adv (lfsr_adv),
        .res      (ures)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            counter_reg    <= 16'd0;
            lfsr_reg       <= SeedReset;
            seed_reg       <= SeedReset;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                seed_reg <= pwdata[15:0];
                lfsr_reg <= pwdata[15:0];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (ures.lfsr_step)
                    begin
                        lfsr_reg <= lfsr_adv;
                    end
                    if (ures.emit)
                    begin
                        // release the held beat, hold the new one
                        if (pend_valid_reg)
                        begin
                            rsp_valid_reg <= 1'b1;
                            rsp_reg       <= pend_reg;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_reg       <= '{message_kind: ures.kind, target_group: ures.group,
                                            packet_id: counter_reg, last: 1'b0};
                        counter_reg    <= counter_reg + 16'd1;
                    end
                    if (scan_end)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SlotIdxW'(1);
                    end
                end
                ST_FLUSH:
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg       <= '{message_kind: pend_reg.message_kind,
                                           target_group: pend_reg.target_group,
                                           packet_id: pend_reg.packet_id, last: 1'b1};
                    end
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/ihgt_slot_table.sv =====
// Slot register file of the group table: one read and one write port.
// Depends on ihgt_pkg.
module ihgt_slot_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ihgt_pkg::SlotIdxW-1:0]       rd_idx,
    output ihgt_pkg::ihgt_slot_t                rd_slot,
    input  logic                                wr_en,
    input  logic [ihgt_pkg::SlotIdxW-1:0]       wr_idx,
    input  ihgt_pkg::ihgt_slot_t                wr_slot
);
    import ihgt_pkg::*;

    ihgt_slot_t slot_reg [GroupSlots];

    assign rd_slot = slot_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GroupSlots; i++)
            begin
                slot_reg[i] <= '{addr: 32'd0, timer: 8'd0, mode: MODE_NON_MEMBER};
            end
        end
        else if (wr_en)
        begin
            slot_reg[wr_idx] <= wr_slot;
        end
    end

endmodule

// ===== sv/ihgt_slot_unit.sv =====
// Shared per-slot update unit: applies one operation to one slot.
// Depends on ihgt_pkg.
module ihgt_slot_unit (
    input  ihgt_pkg::ihgt_req_t     req,
    input  ihgt_pkg::ihgt_slot_t    slot,
    input  logic [15:0]             lfsr_adv,
    output ihgt_pkg::ihgt_unit_res_t res
);
    import ihgt_pkg::*;

    logic       join_ok;
    logic       query_ok;
    logic       selected;
    logic [7:0] delay;
    logic [7:0] rand_t;
    logic [2:0] rand_m;
    logic       arm;

    assign join_ok  = (req.group_ip[31:24] & MulticastMask) == MulticastMask;
    assign query_ok = (req.version_and_header_length == QueryVerIhl) &&
                      (req.message_type == QueryType);
    assign selected = (slot.addr != 32'd0) &&
                      ((req.group_ip == AllSystemsGroup) ||
                       (slot.addr == req.group_ip));
    assign delay    = 8'(9'd1 + {2'b00, req.max_response_time[7:1]});
    assign rand_m   = mod5(lfsr_adv);
    assign rand_t   = (rand_m == 3'd0) ? 8'd1 : 8'(rand_m);
    assign arm      = (slot.mode == MODE_IDLE) ||
                      ((slot.mode == MODE_DELAYING) &&
                       ((slot.timer == 8'd0) || (slot.timer > ReportAllMax)));

    always_comb
    begin
        res           = '0;
        res.slot      = slot;
        res.kind      = KindReport;
        res.group     = slot.addr;
        case (req.operation)
            OpJoin:
            begin
                res.group = req.group_ip;
                if (join_ok)
                begin
                    if (slot.addr == req.group_ip)
                    begin
                        res.stop = 1'b1;
                    end
                    else if (slot.addr == 32'd0)
                    begin
                        res.slot = '{addr: req.group_ip, timer: JoinDelayTicks,
                                     mode: MODE_DELAYING};
                        res.emit = 1'b1;
                        res.stop = 1'b1;
                    end
                end
            end
            OpLeave:
            begin
                res.kind = KindLeave;
                if ((req.group_ip != 32'd0) && (slot.addr == req.group_ip))
                begin
                    res.slot = '{addr: 32'd0, timer: 8'd0, mode: MODE_NON_MEMBER};
                    res.emit = 1'b1;
                    res.stop = 1'b1;
                end
            end
            OpQuery:
            begin
                if (query_ok && selected)
                begin
                    if (slot.mode == MODE_DELAYING)
                    begin
                        if (req.max_response_time < slot.timer)
                        begin
                            res.slot.timer = delay;
                        end
                    end
                    else
                    begin
                        res.slot.mode  = MODE_DELAYING;
                        res.slot.timer = delay;
                    end
                end
            end
            OpTick:
            begin
                if (slot.timer != 8'd0)
                begin
                    res.slot.timer = slot.timer - 8'd1;
                    if ((slot.timer == 8'd1) && (slot.mode == MODE_DELAYING) &&
                        (slot.addr != AllSystemsGroup))
                    begin
                        res.slot.mode = MODE_IDLE;
                        res.emit      = 1'b1;
                    end
                end
            end
            OpReportAll:
            begin
                if (arm)
                begin
                    res.lfsr_step  = 1'b1;
                    res.slot.timer = rand_t;
                    res.slot.mode  = MODE_DELAYING;
                end
            end
            OpLeaveAll:
            begin
                res.kind = KindLeave;
                if (slot.addr != 32'd0)
                begin
                    res.slot = '{addr: 32'd0, timer: 8'd0, mode: MODE_NON_MEMBER};
                    res.emit = 1'b1;
                end
            end
            default:
            begin
                res.stop = 1'b1;
            end
        endcase
    end

endmodule
